// ===== src/ombc_pkg.sv =====
// shared types, constants and the interval table for the one-button menu controller
// no dependencies; every other file refers to this package by scoped names
package ombc_pkg;

  typedef enum logic [2:0] {
    UI_SLIDE    = 3'd0,
    UI_MENU     = 3'd1,
    UI_INTERVAL = 3'd2,
    UI_BRIGHT   = 3'd3,
    UI_INFO     = 3'd4
  } ui_state_t;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_TIMEOUT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MENU_TIMEOUT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_MIN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_STEP = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGES_OK   = 4'd7;

  localparam logic [2:0] INTERVAL_LAST = 3'd6;

  localparam logic [1:0] ENTRY_INTERVAL = 2'd0;
  localparam logic [1:0] ENTRY_BRIGHT   = 2'd1;
  localparam logic [1:0] ENTRY_INFO     = 2'd2;

  typedef struct packed {
    logic        button_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] ui_state;
    logic [1:0] menu_item;
    logic [2:0] interval_index;
    logic [7:0] brightness;
    logic       short_event;
    logic       long_event;
    logic       save_interval;
    logic       save_brightness;
    logic       message_on;
    logic       advance_image;
    logic       redraw_image;
  } out_item_t;

  typedef struct packed {
    logic [15:0] short_min_ms;
    logic [15:0] long_ms;
    logic [15:0] setting_timeout_ms;
    logic [15:0] menu_timeout_ms;
    logic [7:0]  bright_min;
    logic [7:0]  bright_max;
    logic [7:0]  bright_step;
    logic        images_ok;
  } cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } press_ev_t;

  function automatic logic [31:0] interval_ms(input logic [2:0] idx);
    logic [31:0] ms;
    case (idx)
      3'd0:    ms = 32'd5000;
      3'd1:    ms = 32'd30000;
      3'd2:    ms = 32'd60000;
      3'd3:    ms = 32'd300000;
      3'd4:    ms = 32'd900000;
      3'd5:    ms = 32'd1800000;
      3'd6:    ms = 32'd3600000;
      default: ms = 32'd5000;
    endcase
    return ms;
  endfunction

endpackage

// ===== src/ombc_press.sv =====
// press classifier: tracks button edges and hold time, flags short and long presses
// depends on ombc_pkg for the config and event structs
module ombc_press (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  ombc_pkg::in_item_t item,
  input  ombc_pkg::cfg_t     cfg,
  output ombc_pkg::press_ev_t ev
);

  logic        prev_r, prev_nxt;
  logic        held_r, held_nxt;
  logic        ld_r, ld_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [31:0] dur;
  logic [31:0] hold;

  always_comb begin
    held_nxt  = held_r;
    ld_nxt    = ld_r;
    stamp_nxt = stamp_r;
    ev        = '0;
    dur       = item.now_ms - stamp_r;
    if (!item.button_level && prev_r) begin
      held_nxt  = 1'b1;
      stamp_nxt = item.now_ms;
      ld_nxt    = 1'b0;
    end
    if (item.button_level && !prev_r && held_r) begin
      if ((dur > {16'd0, cfg.short_min_ms}) && !ld_r && (dur < {16'd0, cfg.long_ms})) begin
        ev.short_ev = 1'b1;
      end
      held_nxt = 1'b0;
      ld_nxt   = 1'b0;
    end
    hold = item.now_ms - stamp_nxt;
    if (held_nxt && !ld_nxt && (hold > {16'd0, cfg.long_ms})) begin
      ld_nxt     = 1'b1;
      ev.long_ev = 1'b1;
    end
    prev_nxt = item.button_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      held_r  <= 1'b0;
      ld_r    <= 1'b0;
      stamp_r <= '0;
    end else if (go) begin
      prev_r  <= prev_nxt;
      held_r  <= held_nxt;
      ld_r    <= ld_nxt;
      stamp_r <= stamp_nxt;
    end
  end

endmodule

// ===== src/ombc_menu.sv =====
// menu state machine: modes, timeouts, interval and brightness stepping, image pulses
// depends on ombc_pkg for types, codes and the interval table
module ombc_menu #(
  parameter int DEFAULT_INTERVAL = 2,
  parameter int DEFAULT_LEVEL    = 128,
  parameter int MESSAGE_MS       = 2000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [31:0]         now_ms,
  input  ombc_pkg::press_ev_t ev,
  input  ombc_pkg::cfg_t      cfg,
  output ombc_pkg::out_item_t res
);

  localparam logic [2:0]  RST_INTERVAL = 3'(DEFAULT_INTERVAL % 7);
  localparam logic [7:0]  RST_LEVEL    = 8'(DEFAULT_LEVEL);
  localparam logic [31:0] MSG_MS       = 32'(MESSAGE_MS);

  ombc_pkg::ui_state_t mode_r, mode_nxt;
  logic [1:0]  entry_r, entry_nxt;
  logic [2:0]  isel_r, isel_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [31:0] act_r, act_nxt;
  logic [31:0] img_r, img_nxt;
  logic        msg_r, msg_nxt;
  logic [31:0] msgst_r, msgst_nxt;

  logic [2:0] isel_up, isel_dn;
  logic [7:0] level_up, level_dn;
  logic       save_i, save_b, adv, redraw;

  function automatic logic [7:0] clamp_level(input logic signed [9:0] v,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic signed [9:0] t;
    t = v;
    if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
    if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
    return t[7:0];
  endfunction

  assign isel_up  = (isel_r == ombc_pkg::INTERVAL_LAST) ? 3'd0 : isel_r + 3'd1;
  assign isel_dn  = (isel_r == 3'd0) ? ombc_pkg::INTERVAL_LAST : isel_r - 3'd1;
  assign level_up = clamp_level($signed({2'b00, level_r}) + $signed({2'b00, cfg.bright_step}),
                                cfg.bright_min, cfg.bright_max);
  assign level_dn = clamp_level($signed({2'b00, level_r}) - $signed({2'b00, cfg.bright_step}),
                                cfg.bright_min, cfg.bright_max);

  always_comb begin
    mode_nxt  = mode_r;
    entry_nxt = entry_r;
    isel_nxt  = isel_r;
    level_nxt = level_r;
    act_nxt   = act_r;
    img_nxt   = img_r;
    msg_nxt   = msg_r;
    msgst_nxt = msgst_r;
    save_i    = 1'b0;
    save_b    = 1'b0;
    adv       = 1'b0;
    redraw    = 1'b0;

    if (ev.short_ev) begin
      act_nxt = now_ms;
      case (mode_r)
        ombc_pkg::UI_SLIDE: mode_nxt = ombc_pkg::UI_MENU;
        ombc_pkg::UI_MENU: begin
          case (entry_r)
            ombc_pkg::ENTRY_INTERVAL: mode_nxt = ombc_pkg::UI_INTERVAL;
            ombc_pkg::ENTRY_BRIGHT:   mode_nxt = ombc_pkg::UI_BRIGHT;
            ombc_pkg::ENTRY_INFO:     mode_nxt = ombc_pkg::UI_INFO;
            default: begin
              mode_nxt = ombc_pkg::UI_SLIDE;
              if (cfg.images_ok) begin
                redraw  = 1'b1;
                img_nxt = now_ms;
              end
            end
          endcase
        end
        ombc_pkg::UI_INTERVAL: begin
          isel_nxt = isel_up;
          save_i   = 1'b1;
        end
        ombc_pkg::UI_BRIGHT: begin
          if (level_up != level_r) begin
            level_nxt = level_up;
            save_b    = 1'b1;
          end
        end
        default: mode_nxt = ombc_pkg::UI_MENU;
      endcase
    end

    if (ev.long_ev) begin
      act_nxt = now_ms;
      case (mode_r)
        ombc_pkg::UI_SLIDE: begin
          isel_nxt  = isel_up;
          save_i    = 1'b1;
          msg_nxt   = 1'b1;
          msgst_nxt = now_ms;
          img_nxt   = now_ms;
        end
        ombc_pkg::UI_MENU: entry_nxt = entry_r + 2'd1;
        ombc_pkg::UI_INTERVAL: begin
          isel_nxt = isel_dn;
          save_i   = 1'b1;
        end
        ombc_pkg::UI_BRIGHT: begin
          if (level_dn != level_r) begin
            level_nxt = level_dn;
            save_b    = 1'b1;
          end
        end
        default: begin
          mode_nxt = ombc_pkg::UI_SLIDE;
          if (cfg.images_ok) begin
            redraw  = 1'b1;
            img_nxt = now_ms;
          end
        end
      endcase
    end

    if ((mode_nxt inside {ombc_pkg::UI_INTERVAL, ombc_pkg::UI_BRIGHT}) &&
        ((now_ms - act_nxt) > {16'd0, cfg.setting_timeout_ms})) begin
      mode_nxt = ombc_pkg::UI_MENU;
    end
    if ((mode_nxt == ombc_pkg::UI_MENU) &&
        ((now_ms - act_nxt) > {16'd0, cfg.menu_timeout_ms})) begin
      mode_nxt = ombc_pkg::UI_SLIDE;
      if (cfg.images_ok) begin
        redraw  = 1'b1;
        img_nxt = now_ms;
      end
    end

    if (msg_nxt && ((now_ms - msgst_nxt) >= MSG_MS)) begin
      if (cfg.images_ok && (mode_nxt == ombc_pkg::UI_SLIDE)) begin
        redraw  = 1'b1;
        img_nxt = now_ms;
      end
      msg_nxt = 1'b0;
    end

    if (cfg.images_ok && (mode_nxt == ombc_pkg::UI_SLIDE) && !msg_nxt &&
        ((now_ms - img_nxt) >= ombc_pkg::interval_ms(isel_nxt))) begin
      adv     = 1'b1;
      img_nxt = now_ms;
    end

    res.ui_state        = mode_nxt;
    res.menu_item       = entry_nxt;
    res.interval_index  = isel_nxt;
    res.brightness      = level_nxt;
    res.short_event     = ev.short_ev;
    res.long_event      = ev.long_ev;
    res.save_interval   = save_i;
    res.save_brightness = save_b;
    res.message_on      = msg_nxt;
    res.advance_image   = adv;
    res.redraw_image    = redraw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ombc_pkg::UI_SLIDE;
      entry_r <= '0;
      isel_r  <= RST_INTERVAL;
      level_r <= RST_LEVEL;
      act_r   <= '0;
      img_r   <= '0;
      msg_r   <= 1'b0;
      msgst_r <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      entry_r <= entry_nxt;
      isel_r  <= isel_nxt;
      level_r <= level_nxt;
      act_r   <= act_nxt;
      img_r   <= img_nxt;
      msg_r   <= msg_nxt;
      msgst_r <= msgst_nxt;
    end
  end

endmodule

// ===== src/one_button_menu_controller.sv =====
// top level of the one-button menu controller: config registers, input and result registers
// depends on ombc_pkg, ombc_press and ombc_menu
//
// usage: each input transaction on in_valid/in_stall/in_data is one poll with the raw
// button level (1 released, 0 pressed) and a wrapping 32-bit millisecond time.
// every poll gives exactly one result transaction on out_valid/out_stall/out_data
// holding the menu state after the poll and the pulses it raised.
// an accepted poll waits in the input register and is processed once the result register is
// free, which loads the result register and raises out_valid.
// throughput: one poll per cycle while out_stall is low, set by the single pass of the
// press classifier and menu logic between the input register and the result register.
// when the receiver stalls, the result register holds and the input register keeps one
// more poll; beyond that in_stall rises until the result is taken.
// configuration writes on cfg_valid/cfg_ready/cfg_index/cfg_data are always ready and
// take effect on the next poll; unknown indexes are ignored.
// reset (rst_n low, synchronous) empties both registers, restores default settings,
// returns to slideshow and loads the default interval index and brightness.
module one_button_menu_controller #(
  parameter int DEFAULT_INTERVAL = 2,
  parameter int DEFAULT_LEVEL    = 128,
  parameter int MESSAGE_MS       = 2000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ombc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ombc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ombc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ombc_pkg::CFG_DAT_W-1:0]      cfg_data
);

  ombc_pkg::cfg_t      cfg_r;
  ombc_pkg::in_item_t  in_r;
  logic                in_v_r;
  ombc_pkg::out_item_t out_r;
  logic                out_v_r;
  logic                out_free;
  logic                go;
  ombc_pkg::press_ev_t ev;
  ombc_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_v_r || !out_stall;
  assign go        = in_v_r && out_free;
  assign in_stall  = in_v_r && !out_free;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min_ms       <= 16'd50;
      cfg_r.long_ms            <= 16'd1000;
      cfg_r.setting_timeout_ms <= 16'd5000;
      cfg_r.menu_timeout_ms    <= 16'd10000;
      cfg_r.bright_min         <= 8'd10;
      cfg_r.bright_max         <= 8'd255;
      cfg_r.bright_step        <= 8'd25;
      cfg_r.images_ok          <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ombc_pkg::CFG_SHORT_MIN:    cfg_r.short_min_ms       <= cfg_data;
        ombc_pkg::CFG_LONG:         cfg_r.long_ms            <= cfg_data;
        ombc_pkg::CFG_SET_TIMEOUT:  cfg_r.setting_timeout_ms <= cfg_data;
        ombc_pkg::CFG_MENU_TIMEOUT: cfg_r.menu_timeout_ms    <= cfg_data;
        ombc_pkg::CFG_BRIGHT_MIN:   cfg_r.bright_min         <= cfg_data[7:0];
        ombc_pkg::CFG_BRIGHT_MAX:   cfg_r.bright_max         <= cfg_data[7:0];
        ombc_pkg::CFG_BRIGHT_STEP:  cfg_r.bright_step        <= cfg_data[7:0];
        ombc_pkg::CFG_IMAGES_OK:    cfg_r.images_ok          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_r <= res;
    end
  end

  ombc_press u_press (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_r),
    .cfg   (cfg_r),
    .ev    (ev)
  );

  ombc_menu #(
    .DEFAULT_INTERVAL (DEFAULT_INTERVAL),
    .DEFAULT_LEVEL    (DEFAULT_LEVEL),
    .MESSAGE_MS       (MESSAGE_MS)
  ) u_menu (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .now_ms (in_r.now_ms),
    .ev     (ev),
    .cfg    (cfg_r),
    .res    (res)
  );

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.short_event && out_r.long_event))
    else $error("short and long press in one transaction");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with empty input register");

  a_save_b_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.save_brightness) |-> (out_r.ui_state == ombc_pkg::UI_BRIGHT))
    else $error("brightness save outside brightness setting");

  a_adv_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.advance_image) |->
      ((out_r.ui_state == ombc_pkg::UI_SLIDE) && !out_r.message_on))
    else $error("image advance outside running slideshow");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_v_r)
    else $error("processed poll produced no result");

endmodule
